/* rtl/igcfix_pkg.sv */
// ---------------------------------------------------------------------------
// igcfix_pkg
// Shared constants, types and digit helpers for the fix record parser.
// ---------------------------------------------------------------------------
package igcfix_pkg;

  // Length of a complete fix line in characters.
  localparam logic [5:0] LINE_LEN = 6'd40;

  // Characters that the parser looks for.
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Status codes of a finished line.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VOID      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_B     = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;
  localparam logic [2:0] ST_BAD_NUM   = 3'd5;
  localparam logic [2:0] ST_BAD_NS    = 3'd6;
  localparam logic [2:0] ST_BAD_EW    = 3'd7;

  // Minutes are carried in thousandths, so one degree is this many units.
  localparam int unsigned UNITS_PER_DEG = 60000;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;

  // Range limits of the short decimal fields.
  localparam logic [9:0] ACC_MAX  = 10'd999;
  localparam logic [6:0] SATS_MAX = 7'd99;

  typedef struct packed {
    logic bad;   // a non-digit sat in a number position
    logic w;
    logic e;
    logic s;
    logic n;
    logic a;
    logic b;
  } chk_flags_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // value * 10 + digit, wrapped to the field width. The low nibble of an
  // ASCII digit is its value.
  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [7:0] c);
    logic [10:0] t;
    t = {4'b0, v} * 11'd10 + {7'b0, c[3:0]};
    return t[6:0];
  endfunction

  function automatic logic [9:0] acc10(input logic [9:0] v, input logic [7:0] c);
    logic [13:0] t;
    t = {4'b0, v} * 14'd10 + {10'b0, c[3:0]};
    return t[9:0];
  endfunction

  function automatic logic [16:0] acc17(input logic [16:0] v, input logic [7:0] c);
    logic [20:0] t;
    t = {4'b0, v} * 21'd10 + {17'b0, c[3:0]};
    return t[16:0];
  endfunction

endpackage

/* rtl/igc_fix_record_parser_core.sv */
// ---------------------------------------------------------------------------
// igc_fix_record_parser_core
// Parses one flight-log fix line, a character per beat, and returns the
// decoded fix with a status when the line-end beat arrives.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    in_ch, in_line_end
//  out_     output     out_valid / out_ready  out_status and the six fix fields
//
//  An accepted beat is held in the input register; from there its field
//  update is registered into the line state, or for a line end its result
//  into the output register, which offers the result beat until it is taken.
//  A new beat is accepted in every cycle unless a line-end beat waits in
//  the input register; a character beat never waits there. A line-end beat
//  waits only while an earlier result is still held in the output register
//  and out_ready is low.
//  rst_n is synchronous and active low; it empties both registers and clears
//  the collected fields.
// ---------------------------------------------------------------------------
module igc_fix_record_parser_core
  import igcfix_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_line_end,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [18:0]        out_time_of_day,
  output logic signed [23:0] out_latitude,
  output logic signed [26:0] out_longitude,
  output logic signed [17:0] out_altitude,
  output logic [9:0]         out_accuracy,
  output logic [6:0]         out_satellites
);

  // Input register: holds one accepted beat.
  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       end_r;

  // Line state. Each decimal field has its own accumulator.
  logic [5:0]  pos_r,      pos_nxt;
  logic [6:0]  hh_r,       hh_nxt;
  logic [6:0]  mm_r,       mm_nxt;
  logic [6:0]  ss_r,       ss_nxt;
  logic [6:0]  lat_deg_r,  lat_deg_nxt;
  logic [16:0] lat_min_r,  lat_min_nxt;
  logic [9:0]  lon_deg_r,  lon_deg_nxt;
  logic [16:0] lon_min_r,  lon_min_nxt;
  logic [16:0] alt_mag_r,  alt_mag_nxt;
  logic        alt_neg_r,  alt_neg_nxt;
  logic [9:0]  acc_r,      acc_nxt;
  logic [6:0]  sats_r,     sats_nxt;
  chk_flags_t  flags_r,    flags_nxt;

  // Output register.
  logic               out_vld_r,  out_vld_nxt;
  logic [2:0]         status_r,   status_nxt;
  logic [18:0]        tod_r,      tod_nxt;
  logic signed [23:0] lat_r,      lat_nxt;
  logic signed [26:0] lon_r,      lon_nxt;
  logic signed [17:0] alt_r,      alt_nxt;
  logic [9:0]         acc_out_r,  acc_out_nxt;
  logic [6:0]         sats_out_r, sats_out_nxt;

  // The held beat moves on unless it is a line end facing a full, stalled
  // output register.
  logic adv;
  logic dig;
  logic [2:0]  st;
  logic [23:0] lat_mag;
  logic [26:0] lon_mag;
  logic [17:0] alt_ext;

  assign adv      = in_vld_r && (!end_r || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign dig      = is_digit(ch_r);

  // Status, in priority order: empty, tag, length, validity mark, number
  // syntax, hemisphere letters.
  always_comb begin
    if (pos_r == '0) begin
      st = ST_EMPTY;
    end else if (!flags_r.b) begin
      st = ST_NOT_B;
    end else if (pos_r < LINE_LEN) begin
      st = ST_SHORT;
    end else if (!flags_r.a) begin
      st = ST_VOID;
    end else if (flags_r.bad) begin
      st = ST_BAD_NUM;
    end else if (!(flags_r.n || flags_r.s)) begin
      st = ST_BAD_NS;
    end else if (!(flags_r.e || flags_r.w)) begin
      st = ST_BAD_EW;
    end else begin
      st = ST_OK;
    end
  end

  // Angles become thousandths of a minute; the products stay within the
  // field widths for every digit pattern, so no wrap occurs before negation.
  assign lat_mag = {17'b0, lat_deg_r} * 24'(UNITS_PER_DEG) + {7'b0, lat_min_r};
  assign lon_mag = {17'b0, lon_deg_r} * 27'(UNITS_PER_DEG) + {10'b0, lon_min_r};
  assign alt_ext = {1'b0, alt_mag_r};

  always_comb begin
    pos_nxt      = pos_r;
    hh_nxt       = hh_r;
    mm_nxt       = mm_r;
    ss_nxt       = ss_r;
    lat_deg_nxt  = lat_deg_r;
    lat_min_nxt  = lat_min_r;
    lon_deg_nxt  = lon_deg_r;
    lon_min_nxt  = lon_min_r;
    alt_mag_nxt  = alt_mag_r;
    alt_neg_nxt  = alt_neg_r;
    acc_nxt      = acc_r;
    sats_nxt     = sats_r;
    flags_nxt    = flags_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    status_nxt   = status_r;
    tod_nxt      = tod_r;
    lat_nxt      = lat_r;
    lon_nxt      = lon_r;
    alt_nxt      = alt_r;
    acc_out_nxt  = acc_out_r;
    sats_out_nxt = sats_out_r;

    if (adv && end_r) begin
      // Finish the line: load the result and start the next line afresh.
      out_vld_nxt  = 1'b1;
      status_nxt   = st;
      tod_nxt      = '0;
      lat_nxt      = '0;
      lon_nxt      = '0;
      alt_nxt      = '0;
      acc_out_nxt  = '0;
      sats_out_nxt = '0;
      if (st == ST_OK) begin
        tod_nxt      = {12'b0, hh_r} * 19'(SEC_PER_HOUR) +
                       {12'b0, mm_r} * 19'(SEC_PER_MIN) + {12'b0, ss_r};
        lat_nxt      = flags_r.s ? -lat_mag : lat_mag;
        lon_nxt      = flags_r.w ? -lon_mag : lon_mag;
        alt_nxt      = alt_neg_r ? -alt_ext : alt_ext;
        acc_out_nxt  = acc_r;
        sats_out_nxt = sats_r;
      end
      pos_nxt     = '0;
      hh_nxt      = '0;
      mm_nxt      = '0;
      ss_nxt      = '0;
      lat_deg_nxt = '0;
      lat_min_nxt = '0;
      lon_deg_nxt = '0;
      lon_min_nxt = '0;
      alt_mag_nxt = '0;
      alt_neg_nxt = 1'b0;
      acc_nxt     = '0;
      sats_nxt    = '0;
      flags_nxt   = '0;
    end else if (adv && (pos_r < LINE_LEN)) begin
      // A character within the line; anything past the fortieth is dropped.
      pos_nxt = pos_r + 6'd1;
      case (pos_r) inside
        6'd0: begin
          if (ch_r == CH_B) flags_nxt.b = 1'b1;
        end
        [6'd1:6'd2]: begin
          if (dig) hh_nxt = acc7(hh_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd3:6'd4]: begin
          if (dig) mm_nxt = acc7(mm_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd5:6'd6]: begin
          if (dig) ss_nxt = acc7(ss_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd7:6'd8]: begin
          if (dig) lat_deg_nxt = acc7(lat_deg_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd9:6'd13]: begin
          if (dig) lat_min_nxt = acc17(lat_min_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        6'd14: begin
          if (ch_r == CH_N) flags_nxt.n = 1'b1;
          else if (ch_r == CH_S) flags_nxt.s = 1'b1;
        end
        [6'd15:6'd17]: begin
          if (dig) lon_deg_nxt = acc10(lon_deg_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd18:6'd22]: begin
          if (dig) lon_min_nxt = acc17(lon_min_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        6'd23: begin
          if (ch_r == CH_E) flags_nxt.e = 1'b1;
          else if (ch_r == CH_W) flags_nxt.w = 1'b1;
        end
        6'd24: begin
          if (ch_r == CH_A) flags_nxt.a = 1'b1;
        end
        6'd30: begin
          // The first altitude character may be a minus sign instead.
          if (ch_r == CH_MINUS) alt_neg_nxt = 1'b1;
          else if (dig) alt_mag_nxt = acc17(alt_mag_r, ch_r);
          else flags_nxt.bad = 1'b1;
        end
        [6'd31:6'd34]: begin
          if (dig) alt_mag_nxt = acc17(alt_mag_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd35:6'd37]: begin
          if (dig) acc_nxt = acc10(acc_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        [6'd38:6'd39]: begin
          if (dig) sats_nxt = acc7(sats_r, ch_r); else flags_nxt.bad = 1'b1;
        end
        default: begin
          // Pressure altitude is not looked at.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      hh_r      <= '0;
      mm_r      <= '0;
      ss_r      <= '0;
      lat_deg_r <= '0;
      lat_min_r <= '0;
      lon_deg_r <= '0;
      lon_min_r <= '0;
      alt_mag_r <= '0;
      alt_neg_r <= 1'b0;
      acc_r     <= '0;
      sats_r    <= '0;
      flags_r   <= '0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      out_vld_r <= out_vld_nxt;
      pos_r     <= pos_nxt;
      hh_r      <= hh_nxt;
      mm_r      <= mm_nxt;
      ss_r      <= ss_nxt;
      lat_deg_r <= lat_deg_nxt;
      lat_min_r <= lat_min_nxt;
      lon_deg_r <= lon_deg_nxt;
      lon_min_r <= lon_min_nxt;
      alt_mag_r <= alt_mag_nxt;
      alt_neg_r <= alt_neg_nxt;
      acc_r     <= acc_nxt;
      sats_r    <= sats_nxt;
      flags_r   <= flags_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r  <= in_ch;
      end_r <= in_line_end;
    end
    status_r   <= status_nxt;
    tod_r      <= tod_nxt;
    lat_r      <= lat_nxt;
    lon_r      <= lon_nxt;
    alt_r      <= alt_nxt;
    acc_out_r  <= acc_out_nxt;
    sats_out_r <= sats_out_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_status      = status_r;
  assign out_time_of_day = tod_r;
  assign out_latitude    = lat_r;
  assign out_longitude   = lon_r;
  assign out_altitude    = alt_r;
  assign out_accuracy    = acc_out_r;
  assign out_satellites  = sats_out_r;

endmodule

/* rtl/igcfix_checker.sv */
// ---------------------------------------------------------------------------
// igcfix_checker
// Port-level checks on the result channel of the fix record parser.
// ---------------------------------------------------------------------------
module igcfix_checker
  import igcfix_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic [18:0]        out_time_of_day,
  input logic signed [23:0] out_latitude,
  input logic signed [26:0] out_longitude,
  input logic signed [17:0] out_altitude,
  input logic [9:0]         out_accuracy,
  input logic [6:0]         out_satellites
);

  // A result beat is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_latitude) && $stable(out_longitude))
    else $error("result beat dropped or changed while stalled");

  // A rejected line carries no fix.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_time_of_day == '0)
      && (out_latitude == '0) && (out_longitude == '0) && (out_altitude == '0)
      && (out_accuracy == '0) && (out_satellites == '0))
    else $error("fix fields not zero on a failed line");

  // Accuracy and satellite count are three and two decimal digits.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accuracy <= ACC_MAX) && (out_satellites <= SATS_MAX))
    else $error("decimal field beyond its digit count");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind igc_fix_record_parser_core igcfix_checker u_igcfix_checker (.*);
